### rtl/max_min_fair_allocator_core_macros.svh
// Assertion helpers for the max-min fair allocator checker.
// Each macro expects clk and rst_n in scope.
`ifndef MAX_MIN_FAIR_ALLOCATOR_CORE_MACROS_SVH
`define MAX_MIN_FAIR_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define MMFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmfa: same-cycle check failed");

// Next-cycle implication.
`define MMFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmfa: next-cycle check failed");

`endif

### rtl/mmfa_pkg.sv
package mmfa_pkg;

    localparam int DATA_W        = 24;
    localparam int IDX_W         = 4;
    localparam int PDATA_W       = 32;
    localparam int PADDR_W       = 3;
    localparam int MAX_USERS_DEF = 16;

    localparam logic [DATA_W-1:0] CPU_CAP_RST = 24'd2304;
    localparam logic [DATA_W-1:0] MEM_CAP_RST = 24'd4608;

    // Register select, taken from paddr[2]
    localparam logic REG_CPU_CAP = 1'b0;
    localparam logic REG_MEM_CAP = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] cpu_demand;
        logic [DATA_W-1:0] mem_demand;
        logic              last_user;
    } demand_t;

    typedef struct packed {
        logic [IDX_W-1:0]  user_index;
        logic [DATA_W-1:0] cpu_grant;
        logic [DATA_W-1:0] mem_grant;
        logic              last_grant;
    } grant_t;

    typedef struct packed {
        logic count;      // stored user has a nonzero demand
        logic init;       // load capacity, arm the fill
        logic div_start;  // begin the share division of a round
        logic upd;        // need read back from memory is valid
        logic clear;      // drop the unsatisfied count after the fill
    } lane_ctrl_t;

    typedef struct packed {
        logic run;        // resource still filling
        logic div_done;   // share ready
    } lane_stat_t;

endpackage

### rtl/mmfa_ram.sv
module mmfa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/mmfa_div.sv
module mmfa_div #(
    parameter int NW = 24,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    // One quotient bit a cycle, restoring
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = CNTW'(NW);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### rtl/mmfa_lane.sv
module mmfa_lane #(
    parameter int MAX_USERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mmfa_pkg::lane_ctrl_t           ctrl,
    input  logic [mmfa_pkg::DATA_W-1:0]    capacity,
    input  logic [mmfa_pkg::DATA_W-1:0]    need_in,
    output logic [mmfa_pkg::DATA_W-1:0]    need_out,
    output mmfa_pkg::lane_stat_t           stat
);

    import mmfa_pkg::*;

    localparam int CW = $clog2(MAX_USERS + 1);

    logic [DATA_W-1:0] left_reg, left_next;
    logic [CW-1:0]     active_reg, active_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] share_reg, share_next;
    logic [DATA_W-1:0] quotient;
    logic              div_done;
    logic              live;
    logic              take_all;

    mmfa_div #(
        .NW (DATA_W),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (left_reg),
        .divisor  (active_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign live     = !done_reg && (need_in != '0);
    assign take_all = need_in <= share_reg;

    // Satisfied users drop out; the rest take the share of the round
    always_comb
    begin
        if (!live)
        begin
            need_out = need_in;
        end
        else if (take_all)
        begin
            need_out = '0;
        end
        else
        begin
            need_out = need_in - share_reg;
        end
    end

    always_comb
    begin
        left_next   = left_reg;
        active_next = active_reg;
        done_next   = done_reg;
        share_next  = share_reg;
        if (ctrl.clear)
        begin
            active_next = '0;
        end
        else if (ctrl.count)
        begin
            active_next = active_reg + CW'(1);
        end
        if (ctrl.init)
        begin
            left_next = capacity;
            done_next = 1'b0;
        end
        if (ctrl.div_start && (left_reg == '0 || active_reg == '0))
        begin
            done_next = 1'b1;
        end
        if (div_done)
        begin
            share_next = quotient;
            if (quotient == '0)
            begin
                done_next = 1'b1;
            end
        end
        if (ctrl.upd && live)
        begin
            if (take_all)
            begin
                left_next   = left_reg - need_in;
                active_next = active_reg - CW'(1);
            end
            else
            begin
                left_next = left_reg - share_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            active_reg <= '0;
            done_reg   <= 1'b1;
        end
        else
        begin
            left_reg   <= left_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        share_reg <= share_next;
    end

    assign stat.run      = !done_reg;
    assign stat.div_done = div_done;

endmodule

### rtl/max_min_fair_allocator_core.sv
// Max-min fair allocator for CPU and memory.
// Demand channel: one user per transaction (demand_valid / demand_stall), a CPU and a
// memory demand in unsigned 16.8; last_user closes the set. Users load one per cycle
// while demand_stall is low, up to MAX_USERS; extra users are dropped but their
// last_user still starts the fill. Grant channel: one transaction per stored user in
// load order (grant_valid / grant_stall), carrying the index and both grants;
// last_grant marks the final one. After the last user, demand_stall stays high until
// the final grant has been issued. Each fill round runs a start state, the bit-serial
// share divider, a decide state, one pass over the need memory with a read-modify-write
// per cycle, then a drain state. A set sweeps at most n + 1 rounds for n users, then
// closes with one division and decide. Grants leave through the output read and write
// states, as the memories are read through a register; while grant_stall is high the
// held transaction stays put and the grant output waits.
// Capacity registers sit on the APB port at 0x0 (CPU) and 0x4 (memory); writes take
// effect at the next fill. Reset empties the set, restores the default capacities
// (9.0 CPU, 18.0 memory) and leaves the demand memories undefined.
module max_min_fair_allocator_core #(
    parameter int MAX_USERS = mmfa_pkg::MAX_USERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [mmfa_pkg::PDATA_W-1:0]  pwdata,
    output logic [mmfa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          demand_valid,
    output logic                          demand_stall,
    input  mmfa_pkg::demand_t             demand,
    output logic                          grant_valid,
    input  logic                          grant_stall,
    output mmfa_pkg::grant_t              grant
);

    import mmfa_pkg::*;

    localparam int IW = $clog2(MAX_USERS);
    localparam int CW = $clog2(MAX_USERS + 1);
    localparam int RW = $clog2(MAX_USERS + 3);
    localparam int MW = 2 * DATA_W;
    localparam logic [RW-1:0] ROUND_CAP = RW'(MAX_USERS + 2);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DECIDE,
        ST_SWEEP,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [RW-1:0]     round_reg, round_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [IW-1:0]     wr_addr_reg, wr_addr_next;
    logic              out_valid_reg, out_valid_next;
    grant_t            out_reg, out_next;
    logic [DATA_W-1:0] cpu_cap_reg, cpu_cap_next;
    logic [DATA_W-1:0] mem_cap_reg, mem_cap_next;

    logic              accept;
    logic              store;
    logic              cfg_wr;
    logic              idx_is_last;
    logic [IW+IDX_W-1:0] idx_ext;
    logic [MW-1:0]     dem_rd;
    logic [MW-1:0]     need_rd;
    logic [MW-1:0]     need_wr;
    logic [DATA_W-1:0] cpu_need_in;
    logic [DATA_W-1:0] mem_need_in;
    lane_ctrl_t        cpu_ctrl;
    lane_ctrl_t        mem_ctrl;
    lane_stat_t        cpu_stat;
    lane_stat_t        mem_stat;
    logic              ctl_init;
    logic              ctl_div_start;
    logic              ctl_clear;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cpu_cap_next = cpu_cap_reg;
        mem_cap_next = mem_cap_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CPU_CAP: cpu_cap_next = pwdata[DATA_W-1:0];
                REG_MEM_CAP: mem_cap_next = pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CPU_CAP: prdata = {{(PDATA_W-DATA_W){1'b0}}, cpu_cap_reg};
            REG_MEM_CAP: prdata = {{(PDATA_W-DATA_W){1'b0}}, mem_cap_reg};
        endcase
    end

    // Memories
    mmfa_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_USERS)
    ) u_dem_ram (
        .clk   (clk),
        .we    (store),
        .waddr (cnt_reg[IW-1:0]),
        .wdata ({demand.cpu_demand, demand.mem_demand}),
        .raddr (idx_reg),
        .rdata (dem_rd)
    );

    mmfa_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_USERS)
    ) u_need_ram (
        .clk   (clk),
        .we    (wr_pend_reg),
        .waddr (wr_addr_reg),
        .wdata (need_wr),
        .raddr (idx_reg),
        .rdata (need_rd)
    );

    // The first round starts from the loaded demands
    assign cpu_need_in = (round_reg == '0) ? dem_rd[MW-1:DATA_W] : need_rd[MW-1:DATA_W];
    assign mem_need_in = (round_reg == '0) ? dem_rd[DATA_W-1:0]  : need_rd[DATA_W-1:0];

    assign cpu_ctrl = '{count:     store && (demand.cpu_demand != '0),
                        init:      ctl_init,
                        div_start: ctl_div_start,
                        upd:       wr_pend_reg,
                        clear:     ctl_clear};
    assign mem_ctrl = '{count:     store && (demand.mem_demand != '0),
                        init:      ctl_init,
                        div_start: ctl_div_start,
                        upd:       wr_pend_reg,
                        clear:     ctl_clear};

    mmfa_lane #(
        .MAX_USERS (MAX_USERS)
    ) u_cpu_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cpu_ctrl),
        .capacity (cpu_cap_reg),
        .need_in  (cpu_need_in),
        .need_out (need_wr[MW-1:DATA_W]),
        .stat     (cpu_stat)
    );

    mmfa_lane #(
        .MAX_USERS (MAX_USERS)
    ) u_mem_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mem_ctrl),
        .capacity (mem_cap_reg),
        .need_in  (mem_need_in),
        .need_out (need_wr[DATA_W-1:0]),
        .stat     (mem_stat)
    );

    assign demand_stall = (state_reg != ST_LOAD);
    assign accept       = demand_valid && (state_reg == ST_LOAD);
    assign store        = accept && (cnt_reg < CW'(MAX_USERS));
    assign idx_is_last  = (CW'(idx_reg) + CW'(1)) == n_reg;
    assign idx_ext      = {{IDX_W{1'b0}}, idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        round_next     = round_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        out_valid_next = out_valid_reg && grant_stall;
        out_next       = out_reg;
        ctl_init       = 1'b0;
        ctl_div_start  = 1'b0;
        ctl_clear      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (store)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (accept && demand.last_user)
                begin
                    n_next     = store ? cnt_reg + CW'(1) : cnt_reg;
                    ctl_init   = 1'b1;
                    round_next = '0;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                ctl_div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (cpu_stat.div_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                // The opening round always sweeps to seed the need memory
                if (round_reg == ROUND_CAP ||
                    (round_reg != '0 && !cpu_stat.run && !mem_stat.run))
                begin
                    ctl_clear  = 1'b1;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = idx_reg;
                if (idx_is_last)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                round_next = round_reg + RW'(1);
                state_next = ST_DIV_GO;
            end
            ST_OUT_RD:
            begin
                if (!out_valid_reg || !grant_stall)
                begin
                    state_next = ST_OUT_WR;
                end
            end
            ST_OUT_WR:
            begin
                out_valid_next      = 1'b1;
                out_next.user_index = idx_ext[IDX_W-1:0];
                out_next.cpu_grant  = dem_rd[MW-1:DATA_W] - need_rd[MW-1:DATA_W];
                out_next.mem_grant  = dem_rd[DATA_W-1:0] - need_rd[DATA_W-1:0];
                out_next.last_grant = idx_is_last;
                if (idx_is_last)
                begin
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_OUT_RD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            round_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
            cpu_cap_reg   <= CPU_CAP_RST;
            mem_cap_reg   <= MEM_CAP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            round_reg     <= round_next;
            wr_pend_reg   <= wr_pend_next;
            wr_addr_reg   <= wr_addr_next;
            out_valid_reg <= out_valid_next;
            cpu_cap_reg   <= cpu_cap_next;
            mem_cap_reg   <= mem_cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign grant_valid = out_valid_reg;
    assign grant       = out_reg;

endmodule

### rtl/mmfa_checker.sv
`include "max_min_fair_allocator_core_macros.svh"

module mmfa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              demand_valid,
    input logic              demand_stall,
    input mmfa_pkg::demand_t demand,
    input logic              grant_valid,
    input logic              grant_stall,
    input mmfa_pkg::grant_t  grant
);

    // Hold a stalled grant transaction
    `MMFA_ASSERT_NEXT(a_grant_hold, grant_valid && grant_stall, grant_valid && $stable(grant))

    // No loading while a set is still being emitted
    `MMFA_ASSERT_NOW(a_emit_blocks_load, grant_valid && !grant.last_grant, demand_stall)

    // The last user closes the set and starts the fill
    `MMFA_ASSERT_NEXT(a_last_starts_fill, demand_valid && !demand_stall && demand.last_user,
        demand_stall)

    // Loading stays open until the last user
    `MMFA_ASSERT_NEXT(a_load_stays_open, demand_valid && !demand_stall && !demand.last_user,
        !demand_stall)

endmodule

bind max_min_fair_allocator_core mmfa_checker u_mmfa_checker (.*);

### test/max_min_fair_allocator_core_tb.sv
`timescale 1ns / 100ps

module max_min_fair_allocator_core_tb;
    import mmfa_pkg::*;

    localparam int USERS      = MAX_USERS_DEF;
    localparam int CYCLE_CAP  = 800000;
    localparam int TAIL_WAIT  = 64;
    localparam int RAND_QUOTA = 13;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 demand_valid;
    logic                 demand_stall;
    demand_t              demand;
    logic                 grant_valid;
    logic                 grant_stall;
    grant_t               grant;

    int cycles;

    max_min_fair_allocator_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .demand_valid (demand_valid),
        .demand_stall (demand_stall),
        .demand       (demand),
        .grant_valid  (grant_valid),
        .grant_stall  (grant_stall),
        .grant        (grant)
    );

    // Tracks the demand set being loaded and the grants it is owed.
    class grant_book;
        grant_t          due_grants[$];
        logic [23:0]     cpu_cap;
        logic [23:0]     mem_cap;
        logic [23:0]     cpu_need[USERS];
        logic [23:0]     mem_need[USERS];
        int unsigned     award[USERS];
        int              stored;
        int              mismatches;
        int              checked;
        int              sets;
        int              users;

        function new();
            cpu_cap    = CPU_CAP_RST;
            mem_cap    = MEM_CAP_RST;
            stored     = 0;
            mismatches = 0;
            checked    = 0;
            sets       = 0;
            users      = 0;
        endfunction

        function void set_cap(logic sel, logic [23:0] val);
            if (sel == REG_MEM_CAP)
                mem_cap = val;
            else
                cpu_cap = val;
        endfunction

        // Progressive filling of one resource over the stored users, into award[].
        function void fill_resource(bit is_mem, logic [23:0] cap);
            int unsigned need[USERS];
            int unsigned left;
            int unsigned share;
            int unsigned active;
            left   = cap;
            active = 0;
            for (int i = 0; i < stored; i++)
            begin
                need[i]  = is_mem ? mem_need[i] : cpu_need[i];
                award[i] = 0;
                if (need[i] != 0)
                    active++;
            end
            for (int r = 0; r < USERS + 2; r++)
            begin
                if (left == 0 || active == 0)
                    break;
                // share stays fixed for the whole round
                share = left / active;
                if (share == 0)
                    break;
                for (int i = 0; i < stored; i++)
                begin
                    if (need[i] == 0)
                        continue;
                    if (need[i] <= share)
                    begin
                        award[i] += need[i];
                        left     -= need[i];
                        need[i]   = 0;
                        active--;
                    end
                    else
                    begin
                        need[i]  -= share;
                        left     -= share;
                        award[i] += share;
                    end
                end
            end
        endfunction

        function void take_demand(demand_t d);
            logic [23:0] cpu_part[USERS];
            grant_t      g;
            users++;
            // drop users beyond a full store, but still honour their last flag
            if (stored < USERS)
            begin
                cpu_need[stored] = d.cpu_demand;
                mem_need[stored] = d.mem_demand;
                stored++;
            end
            if (d.last_user)
            begin
                fill_resource(1'b0, cpu_cap);
                for (int k = 0; k < stored; k++)
                    cpu_part[k] = award[k][23:0];
                fill_resource(1'b1, mem_cap);
                for (int k = 0; k < stored; k++)
                begin
                    g.user_index = k[IDX_W-1:0];
                    g.cpu_grant  = cpu_part[k];
                    g.mem_grant  = award[k][23:0];
                    g.last_grant = (k == stored - 1);
                    due_grants.push_back(g);
                end
                stored = 0;
                sets++;
            end
        endfunction

        function void report(string what, grant_t want, grant_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected idx %0d cpu %h mem %h last %b, got idx %0d cpu %h mem %h last %b",
                         $realtime, what, want.user_index, want.cpu_grant, want.mem_grant,
                         want.last_grant, got.user_index, got.cpu_grant, got.mem_grant,
                         got.last_grant);
        endfunction

        function void match_grant(grant_t got);
            grant_t want;
            checked++;
            if (due_grants.size() == 0)
            begin
                report("unexpected grant", '0, got);
                return;
            end
            want = due_grants.pop_front();
            if (got.user_index !== want.user_index || got.cpu_grant !== want.cpu_grant ||
                got.mem_grant !== want.mem_grant || got.last_grant !== want.last_grant)
                report("grant mismatch", want, got);
        endfunction
    endclass

    grant_book book;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Grant side back-pressure: calm stretches, short flickers, the odd long hold.
    initial
    begin
        int mode;
        forever
        begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
            begin
                grant_stall <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
            else if (mode < 9)
            begin
                grant_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                grant_stall <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                grant_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && grant_valid && !grant_stall)
                book.match_grant(grant);
        end
    end

    task automatic write_cap(input logic sel, input logic [23:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {8'h00, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_cap(sel, val);
        @(posedge clk);
    endtask

    task automatic pause_demand(input bit calm);
        int g;
        g = 0;
        if (!calm)
            g = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(6, 30);
        if (g > 0)
        begin
            demand_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_user(input logic [23:0] c, input logic [23:0] m, input logic last,
                             input bit calm);
        demand_t d;
        d.cpu_demand = c;
        d.mem_demand = m;
        d.last_user  = last;
        demand       <= d;
        demand_valid <= 1'b1;
        do
            @(posedge clk);
        while (demand_stall);
        book.take_demand(d);
        pause_demand(calm);
    endtask

    // Hold off until every grant has been taken and the block has gone quiet.
    task automatic drain_grants();
        demand_valid <= 1'b0;
        while (book.due_grants.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // Demands half the time scaled to the fair share so the fill runs several rounds.
    function automatic logic [23:0] pick_need(input logic [23:0] cap, input int n);
        int unsigned s;
        int unsigned lo;
        int unsigned hi;
        s  = cap / n;
        lo = s / 2;
        hi = s * 2 + 1;
        if (hi > 24'hFFFFFF)
            hi = 24'hFFFFFF;
        case ($urandom_range(0, 9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 8));
            3, 4:    return 24'($urandom);
            default: return 24'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic random_phase(input int quota);
        int done;
        int n;
        int r;
        bit calm;
        done = 0;
        while (done < quota)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
                n = $urandom_range(1, 5);
            else if (r < 17)
                n = $urandom_range(6, USERS);
            else
                n = $urandom_range(USERS + 1, USERS + 4);
            calm = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < n; i++)
                send_user(pick_need(book.cpu_cap, n < USERS ? n : USERS),
                          pick_need(book.mem_cap, n < USERS ? n : USERS), i == n - 1, calm);
            done += n;
        end
    endtask

    initial
    begin
        int settings;
        book         = new();
        settings     = 1;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        demand_valid <= 1'b0;
        demand       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default capacities: mixed demands, one huge user, one idle user, overfull store
        send_user(24'h000100, 24'h000000, 1'b0, 1'b0);
        send_user(24'h000500, 24'h001000, 1'b0, 1'b0);
        send_user(24'h000A00, 24'h000800, 1'b1, 1'b0);
        send_user(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_user(24'h000000, 24'h000000, 1'b1, 1'b0);
        for (int i = 0; i <= USERS; i++)
            send_user(i == USERS ? 24'hFFFFFF : 24'(i * 64),
                      i == USERS ? 24'hFFFFFF : 24'(24'h1000 - i * 32), i == USERS, 1'b0);
        drain_grants();

        // tiny CPU capacity forces a zero share, no memory at all
        write_cap(REG_CPU_CAP, 24'd5);
        write_cap(REG_MEM_CAP, 24'd0);
        settings++;
        send_user(24'd3, 24'd7, 1'b0, 1'b0);
        send_user(24'd1, 24'd0, 1'b0, 1'b0);
        send_user(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        send_user(24'd2, 24'd1, 1'b1, 1'b0);
        drain_grants();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cap(REG_CPU_CAP, 24'hFFFFFF);
                    write_cap(REG_MEM_CAP, 24'hFFFFFF);
                end
                1:
                begin
                    write_cap(REG_CPU_CAP, 24'($urandom));
                    write_cap(REG_MEM_CAP, 24'($urandom));
                end
                2:
                begin
                    write_cap(REG_CPU_CAP, 24'($urandom_range(1, 48)));
                    write_cap(REG_MEM_CAP, 24'($urandom_range(0, 65535)));
                end
                3:
                begin
                    write_cap(REG_CPU_CAP, CPU_CAP_RST);
                    write_cap(REG_MEM_CAP, MEM_CAP_RST);
                end
                4:
                begin
                    write_cap(REG_CPU_CAP, 24'hFFFFFF);
                    write_cap(REG_MEM_CAP, 24'd1);
                end
                5:
                begin
                    write_cap(REG_CPU_CAP, 24'($urandom_range(256, 65535)));
                    write_cap(REG_MEM_CAP, 24'd0);
                end
                default:
                begin
                    write_cap(REG_CPU_CAP, 24'($urandom));
                    write_cap(REG_MEM_CAP, 24'($urandom_range(1, 300)));
                end
            endcase
            settings++;
            random_phase(RAND_QUOTA);
            drain_grants();
        end

        $display("Loaded %0d users in %0d sets across %0d capacity settings, %0d grants checked.",
                 book.users, book.sets, settings, book.checked);
        if (book.mismatches == 0 && book.due_grants.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
